/* rtl/core/lzwh_pkg.sv */
// ----------------------------------------------------------------------------
// lzwh_pkg
// Shared types, codes and constants of the LZW dictionary hash table.
// ----------------------------------------------------------------------------
package lzwh_pkg;

    localparam int TABLE_SIZE_DEF = 4096;
    localparam int ROOT_COUNT     = 256;

    localparam int REQ_W    = 2;
    localparam int SYM_W    = 8;
    localparam int CODE_W   = 12;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 12;
    localparam int PAIR_W   = CODE_W + SYM_W;
    // stored entry: valid flag above the {parent_code, symbol} pair
    localparam int ENTRY_W  = PAIR_W + 1;

    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_PROBE,
        S_DONE
    } t_state;

endpackage

/* rtl/core/lzwh_ifs.sv */
// ----------------------------------------------------------------------------
// lzwh_ifs
// Request and response channels of the LZW dictionary hash table.
// ----------------------------------------------------------------------------
interface lzwh_req_if;
    logic                        valid;
    logic                        ready;
    logic [lzwh_pkg::REQ_W-1:0]  req_type;
    logic [lzwh_pkg::SYM_W-1:0]  symbol;
    logic [lzwh_pkg::CODE_W-1:0] parent_code;

    modport source (output valid, output req_type, output symbol, output parent_code,
                    input ready);
    modport sink   (input valid, input req_type, input symbol, input parent_code,
                    output ready);
endinterface

interface lzwh_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lzwh_pkg::STATUS_W-1:0] status;
    logic [lzwh_pkg::SLOT_W-1:0]   slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

/* rtl/core/lzwh_mem.sv */
// ----------------------------------------------------------------------------
// lzwh_mem
// Single-port-write, single-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
module lzwh_mem #(
    parameter int DEPTH = lzwh_pkg::TABLE_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [lzwh_pkg::ENTRY_W-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [lzwh_pkg::ENTRY_W-1:0] o_rdata
);
    import lzwh_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/lzwh_ctrl.sv */
// ----------------------------------------------------------------------------
// lzwh_ctrl
// Probe sequencer: hashes the pair, walks the table one slot a cycle, sweeps
// the valid flags on clear and after reset, and holds the response register.
// ----------------------------------------------------------------------------
module lzwh_ctrl #(
    parameter int TABLE_SIZE = lzwh_pkg::TABLE_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lzwh_req_if.sink                          i_req,
    lzwh_rsp_if.source                        o_rsp,
    output logic                              o_mem_we,
    output logic [$clog2(TABLE_SIZE)-1:0]     o_mem_waddr,
    output logic [lzwh_pkg::ENTRY_W-1:0]      o_mem_wdata,
    output logic [$clog2(TABLE_SIZE)-1:0]     o_mem_raddr,
    input  logic [lzwh_pkg::ENTRY_W-1:0]      i_mem_rdata
);
    import lzwh_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int HASH_W = (IDX_W > CODE_W + 1) ? IDX_W : CODE_W + 1;
    localparam logic [IDX_W-1:0] ROOT_IDX  = IDX_W'(ROOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
    localparam logic [IDX_W-1:0] LAST_PROBE = IDX_W'(TABLE_SIZE - ROOT_COUNT - 1);

    t_state              r_state, n_state;
    logic [REQ_W-1:0]    r_req, n_req;
    logic [PAIR_W-1:0]   r_pair, n_pair;
    logic [IDX_W-1:0]    r_cur, n_cur;
    logic [IDX_W-1:0]    r_cnt, n_cnt;
    logic                r_clr, n_clr;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;

    logic [HASH_W-1:0]   w_hash;
    logic [IDX_W-1:0]    w_home;
    logic [IDX_W-1:0]    w_start;
    logic [IDX_W-1:0]    w_next;
    logic                w_rd_valid;
    logic [PAIR_W-1:0]   w_rd_pair;
    logic                w_out_free;

    assign w_hash  = HASH_W'({i_req.parent_code, 1'b0}) ^ HASH_W'(i_req.symbol);
    assign w_home  = w_hash[IDX_W-1:0];
    assign w_start = (w_home < ROOT_IDX) ? ROOT_IDX : w_home;
    // wrap past the last slot back to the first non-root slot
    assign w_next  = (r_cur == LAST_IDX) ? ROOT_IDX : r_cur + 1'b1;

    assign w_rd_valid = i_mem_rdata[ENTRY_W-1];
    assign w_rd_pair  = i_mem_rdata[PAIR_W-1:0];
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // next state
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_pair       = r_pair;
        n_cur        = r_cur;
        n_cnt        = r_cnt;
        n_clr        = r_clr;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        unique case (r_state)
            S_SWEEP: begin
                if (r_cur == LAST_IDX) begin
                    n_clr = 1'b0;
                    n_state = r_clr ? S_DONE : S_IDLE;
                end else begin
                    n_cur = r_cur + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req        = i_req.req_type;
                    n_pair       = {i_req.parent_code, i_req.symbol};
                    n_cur        = w_start;
                    n_cnt        = '0;
                    n_res_status = ST_OK;
                    n_res_slot   = '0;
                    if (i_req.req_type == REQ_LOOKUP || i_req.req_type == REQ_INSERT) begin
                        n_state = S_PROBE;
                    end else if (i_req.req_type == REQ_CLEAR) begin
                        n_state = S_SWEEP;
                        n_cur   = ROOT_IDX;
                        n_clr   = 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PROBE: begin
                // read data belongs to r_cur, the read of w_next is already issued
                if (!w_rd_valid) begin
                    if (r_req == REQ_INSERT) begin
                        n_res_status = ST_OK;
                        n_res_slot   = SLOT_W'(r_cur);
                    end else begin
                        n_res_status = ST_MISS;
                    end
                    n_state = S_DONE;
                end else if (r_req == REQ_LOOKUP && w_rd_pair == r_pair) begin
                    n_res_status = ST_OK;
                    n_res_slot   = SLOT_W'(r_cur);
                    n_state      = S_DONE;
                end else if (r_cnt == LAST_PROBE) begin
                    n_res_status = (r_req == REQ_LOOKUP) ? ST_MISS : ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_cur = w_next;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs and response register
    always_comb begin
        i_req.ready  = (r_state == S_IDLE);
        o_mem_raddr  = (r_state == S_IDLE) ? w_start : w_next;
        o_mem_waddr  = r_cur;
        o_mem_we     = (r_state == S_SWEEP)
                    || (r_state == S_PROBE && !w_rd_valid && r_req == REQ_INSERT);
        o_mem_wdata  = (r_state == S_SWEEP) ? '0 : {1'b1, r_pair};

        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        if (r_state == S_DONE && w_out_free) begin
            n_out_valid  = 1'b1;
            n_out_status = r_res_status;
            n_out_slot   = r_res_slot;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        o_rsp.valid  = r_out_valid;
        o_rsp.status = r_out_status;
        o_rsp.slot   = r_out_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_cur       <= ROOT_IDX;
            r_clr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_pair       <= n_pair;
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

endmodule

/* rtl/core/lzw_dictionary_hash_table_top.sv */
// ----------------------------------------------------------------------------
// lzw_dictionary_hash_table_top
// LZW dictionary store with linear probing over one entry memory.
// ----------------------------------------------------------------------------
// A request is accepted in the idle state, one slot is probed per cycle and
// the result then passes through the done state to the response register; a
// lookup or insert probes 1 to TABLE_SIZE - 256 slots. The single read port of
// the entry memory, read once per cycle, sets that probe rate. A clear sweeps
// the non-root valid flags one slot a cycle and then reports through the done
// state. After reset the same sweep runs, and no request is accepted until it
// ends. TABLE_SIZE must be a power of two. A new request is taken while a
// response still waits.
module lzw_dictionary_hash_table_top #(
    parameter int TABLE_SIZE = lzwh_pkg::TABLE_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lzwh_req_if.sink   i_req,
    lzwh_rsp_if.source o_rsp
);
    import lzwh_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);

    logic               w_mem_we;
    logic [IDX_W-1:0]   w_mem_waddr;
    logic [ENTRY_W-1:0] w_mem_wdata;
    logic [IDX_W-1:0]   w_mem_raddr;
    logic [ENTRY_W-1:0] w_mem_rdata;

    lzwh_ctrl #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    lzwh_mem #(
        .DEPTH (TABLE_SIZE)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

`ifndef SYNTHESIS
    // roots are never written
    a_no_root_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (w_mem_waddr >= IDX_W'(ROOT_COUNT)))
        else $error("write into root region");

    // no request is taken while the memory is being written
    a_no_accept_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> !i_req.ready)
        else $error("request accepted during memory write");

    // a miss or a full table never reports a slot
    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.slot == '0))
        else $error("failed request reports a slot");

    // a reported slot is never a root
    a_slot_not_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.slot != '0) |-> (o_rsp.slot >= SLOT_W'(ROOT_COUNT)
            || TABLE_SIZE > (1 << SLOT_W)))
        else $error("root slot reported");
`endif

endmodule
